/* hdl/bchq_pkg.sv */
// Shared types and constants for the button click and hold qualifier.
// No dependencies; imported by every module of the block.
package bchq_pkg;

    localparam int unsigned CNT_W    = 8;
    localparam int unsigned IDX_W    = 1;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [CNT_W-1:0] HOLD_SECONDS_RST   = 8'd3;
    localparam logic [CNT_W-1:0] WINDOW_SECONDS_RST = 8'd3;
    localparam logic [CNT_W-1:0] CLICK_MAX          = 8'hFF;
    localparam logic [CNT_W-1:0] ONE_CLICK          = 8'd1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_HOLD_SECONDS   = 1'b0;
    localparam logic [IDX_W-1:0] REG_WINDOW_SECONDS = 1'b1;

    // event kinds; code 3 is unused and changes nothing
    typedef enum logic [1:0] {
        OP_EDGE   = 2'd0,
        OP_EXPIRY = 2'd1,
        OP_TICK   = 2'd2
    } event_op_t;

    typedef struct packed {
        logic [CNT_W-1:0] hold_seconds;
        logic [CNT_W-1:0] window_seconds;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic       pin_level;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0] click_total;
        logic             window_closed;
        logic             long_press;
        logic             single_click;
        logic             click_seen;
        logic             led_level;
    } result_t;

endpackage

/* hdl/bchq_core.sv */
// Qualifier state registers and combinational event update.
// Depends on bchq_pkg.
module bchq_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  bchq_pkg::item_t  item,
    input  bchq_pkg::cfg_t   cfg,
    output bchq_pkg::result_t result
);
    import bchq_pkg::*;

    logic             armed_reg, armed_next;
    logic             pend_reg, pend_next;
    logic             wopen_reg, wopen_next;
    logic [CNT_W-1:0] clicks_reg, clicks_next;
    logic [CNT_W-1:0] wcnt_reg, wcnt_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             led_reg, led_next;

    logic             seen, single, lng, closed;
    logic [CNT_W-1:0] wcnt_inc, held_inc;
    logic             hold_hit, win_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg  <= 1'b1;
            pend_reg   <= 1'b0;
            wopen_reg  <= 1'b0;
            clicks_reg <= '0;
            wcnt_reg   <= '0;
            held_reg   <= '0;
            led_reg    <= 1'b0;
        end else if (step) begin
            armed_reg  <= armed_next;
            pend_reg   <= pend_next;
            wopen_reg  <= wopen_next;
            clicks_reg <= clicks_next;
            wcnt_reg   <= wcnt_next;
            held_reg   <= held_next;
            led_reg    <= led_next;
        end
    end

    assign wcnt_inc = wcnt_reg + 1'b1;
    assign held_inc = item.pin_level ? held_reg + 1'b1 : '0;
    // zero limit disables the check
    assign hold_hit = (cfg.hold_seconds != '0) && (held_inc == cfg.hold_seconds);
    assign win_hit  = (cfg.window_seconds != '0) && (wcnt_inc == cfg.window_seconds);

    always_comb begin
        armed_next  = armed_reg;
        pend_next   = pend_reg;
        wopen_next  = wopen_reg;
        clicks_next = clicks_reg;
        wcnt_next   = wcnt_reg;
        held_next   = held_reg;
        led_next    = led_reg;
        seen        = 1'b0;
        single      = 1'b0;
        lng         = 1'b0;
        closed      = 1'b0;
        case (event_op_t'(item.op))
            OP_EDGE: begin
                if (armed_reg) begin
                    armed_next = 1'b0;
                    pend_next  = 1'b1;
                end
            end
            OP_EXPIRY: begin
                if (pend_reg && item.pin_level) begin
                    led_next   = ~led_reg;
                    armed_next = 1'b1;
                    pend_next  = 1'b0;
                    wopen_next = 1'b1;
                    if (clicks_reg != CLICK_MAX) begin
                        clicks_next = clicks_reg + 1'b1;
                    end
                    seen = 1'b1;
                end
            end
            OP_TICK: begin
                if (wopen_reg) begin
                    wcnt_next = wcnt_inc;
                    held_next = held_inc;
                    if (hold_hit) begin
                        // long press restarts the window; no window judgement
                        led_next    = ~led_reg;
                        held_next   = '0;
                        clicks_next = '0;
                        wcnt_next   = '0;
                        wopen_next  = 1'b0;
                        lng         = 1'b1;
                    end else if (win_hit) begin
                        if (clicks_reg == ONE_CLICK) begin
                            led_next = ~led_reg;
                            single   = 1'b1;
                        end
                        clicks_next = '0;
                        wcnt_next   = '0;
                        wopen_next  = 1'b0;
                        closed      = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.led_level     = led_next;
        result.click_seen    = seen;
        result.single_click  = single;
        result.long_press    = lng;
        result.window_closed = closed;
        result.click_total   = clicks_next;
    end

endmodule

/* hdl/bchq_out_stage.sv */
// Result register with valid/ready handshake toward the result channel.
// Depends on bchq_pkg.
module bchq_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  bchq_pkg::result_t load_data,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output bchq_pkg::result_t out_data
);
    import bchq_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // slot can take a word when empty or draining this cycle
    assign free = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hdl/button_click_and_hold_qualifier.sv */
// Top level of the button click and hold qualifier.
// Depends on bchq_pkg, bchq_core and bchq_out_stage.
//
// Usage:
//   Events enter on the s_ stream: s_tuser carries the event kind (edge,
//   debounce expiry, one-second tick), s_tdata bit 0 the sampled pin level.
//   Each event yields exactly one result word on the m_ stream: LED level,
//   the click / single-click / long-press / window-closed flags and the
//   saturating click count of the current window.
//   Flow: an accepted word is registered in the input stage; once the result
//   slot is free, the state update and the result register load happen on
//   the same edge, which raises m_tvalid.
//   Throughput: one event per cycle while m_tready stays high; the state update is a single pass of
//   small 8-bit compare/increment logic between the input and result
//   registers.
//   Stall: when m_tready is low the result register holds, the input word
//   waits in its register and s_tready drops once both are full; nothing
//   is lost or repeated.
//   Reset (aresetn low, synchronous): both stages empty, block armed, no
//   pending debounce, window closed, counters and LED zero, both limits 3.
//   Configuration: cfg_wr_en writes cfg_wdata to the register cfg_addr
//   selects (0 hold seconds, 1 window seconds); write only while idle.
module button_click_and_hold_qualifier (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bchq_pkg::IN_DATA_W-1:0] s_tdata,   // [0] pin_level, [7:1] zero
    input  logic [bchq_pkg::IN_USER_W-1:0] s_tuser,   // [1:0] op
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] led_level, [1] click_seen, [2] single_click, [3] long_press,
    // [4] window_closed, [12:5] click_total, [15:13] zero
    output logic [bchq_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [bchq_pkg::IDX_W-1:0]     cfg_addr,
    input  logic [bchq_pkg::CNT_W-1:0]     cfg_wdata
);
    import bchq_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_free;
    logic    advance;
    result_t core_result;
    result_t out_word;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_seconds   <= HOLD_SECONDS_RST;
            cfg_reg.window_seconds <= WINDOW_SECONDS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HOLD_SECONDS:   cfg_reg.hold_seconds   <= cfg_wdata;
                REG_WINDOW_SECONDS: cfg_reg.window_seconds <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register: an event moves into the core when the result slot frees
    assign advance  = in_valid_reg && out_free;
    assign s_tready = aresetn && (!in_valid_reg || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op        <= s_tuser;
            in_item_reg.pin_level <= s_tdata[0];
        end
    end

    bchq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    bchq_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .load_data (core_result),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_word};

    // ---------------------------------------------------------------- checks
    // a debounce check is pending only while disarmed
    a_pend_disarmed: assert property (@(posedge aclk) disable iff (!aresetn)
        !(u_core.pend_reg && u_core.armed_reg))
        else $error("debounce pending while armed");

    // an event is at most one of a click, a long press or a window close, never two of them
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(m_tdata[4:1] & 4'b1101) <= 1)
        else $error("conflicting result flags");

    // any restart leaves the click count cleared
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[3] || m_tdata[4])) |-> (m_tdata[12:5] == '0))
        else $error("click count survives a restart");

    // an accepted click is always counted
    a_click_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> (m_tdata[12:5] != '0))
        else $error("click seen with zero count");

endmodule
